// ===== hdl/dqs_pkg.sv =====
package dqs_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_FIND       = 3'd4,
        CMD_CLEAR      = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_EMPTY     = 2'd1,
        STS_FULL      = 2'd2,
        STS_NOT_FOUND = 2'd3
    } status_t;

endpackage

// ===== hdl/dqs_ram.sv =====
module dqs_ram
    import dqs_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int ADDR_W     = $clog2(DEPTH)
)
(
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output logic [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port; data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/double_ended_queue_with_search.sv =====
// Bounded double-ended queue of DEPTH entries with a find-first search.
// Input channel (in_valid / in_stall) carries one command per transfer:
// cmd (push front, push back, pop front, pop back, find, clear) and value.
// Output channel (out_valid / out_stall) returns exactly one result per
// command: status, position (first match from the front) and count.
// Push, pop, clear and unused codes give their result on the clock edge
// after the input transfer. A find on a non-empty queue walks the ring
// memory one entry per cycle through its registered read port and gives
// its result on the first match or after the last entry; a find on an
// empty queue answers not found, like the other commands.
// Throughput: one command per cycle except find, if the receiver does not
// stall; a find holds the block to the end of its walk (one RAM read port).
// A result sits in an output register; the next command is taken while
// that register is being drained in the same cycle.
// When the receiver stalls, the result holds and in_stall rises, so no
// command is taken until a slot for its result is free.
// Reset (rst_n, async, active low) empties the queue: front and occupancy go
// to zero. Entry RAM contents are not cleared; only written slots are read.
module double_ended_queue_with_search
    import dqs_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // command channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [CMD_W-1:0]           cmd,
    input  logic signed [VALUE_W-1:0]  value,
    // result channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [STATUS_W-1:0]        status,
    output logic [POS_W-1:0]           position,
    output logic [COUNT_W-1:0]         count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W+1)'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    // one-hot controller states
    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_SEARCH = 2'b10
    } state_t;

    // ring address: (base + off) mod DEPTH, both operands below DEPTH
    function automatic logic [IDX_W-1:0] ring_add(
        input logic [IDX_W-1:0] base,
        input logic [IDX_W-1:0] off
    );
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_X)
        begin
            sum = sum - DEPTH_X;
        end
        return sum[IDX_W-1:0];
    endfunction

    state_t state_reg, state_next;

    logic [IDX_W-1:0]      front_reg, front_next;
    logic [CNT_W-1:0]      occ_reg, occ_next;

    // search walk: rd_idx is the next offset to read, cmp_idx the offset
    // whose data sits on the RAM output when cmp_vld is set
    logic [CNT_W-1:0]      rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;

    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [COUNT_W-1:0]    count_reg, count_next;

    logic                  ram_wr_en;
    logic [IDX_W-1:0]      ram_wr_addr;
    logic                  ram_rd_en;
    logic [IDX_W-1:0]      ram_rd_addr;
    logic [DATA_WIDTH-1:0] ram_rd_data;

    logic                  out_free;
    logic                  in_xfer;
    logic [DATA_WIDTH-1:0] in_key;
    logic [IDX_W-1:0]      front_dec;
    logic                  is_full;
    logic                  is_empty;
    logic                  hit;
    logic                  last_cmp;

    dqs_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_W     (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (in_key),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // output register is free if empty or drained this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || !out_free;
    assign in_xfer  = in_valid && !in_stall;

    // value is taken as an unsigned bit pattern
    assign in_key    = DATA_WIDTH'($unsigned(value));
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - 1'b1;
    assign is_full   = (occ_reg == DEPTH_C);
    assign is_empty  = (occ_reg == '0);
    assign hit       = cmp_vld_reg && (ram_rd_data == key_reg);
    assign last_cmp  = cmp_vld_reg && (CNT_W'(cmp_idx_reg + 1'b1) == occ_reg);

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        occ_next       = occ_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_vld_next   = cmp_vld_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = front_dec;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = ring_add(front_reg, rd_idx_reg[IDX_W-1:0]);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    status_next    = STS_OK;
                    pos_next       = '0;
                    out_valid_next = 1'b1;
                    case (cmd)
                        CMD_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                status_next = STS_FULL;
                            end
                            else
                            begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = front_dec;
                                front_next  = front_dec;
                                occ_next    = occ_reg + 1'b1;
                            end
                        end
                        CMD_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                status_next = STS_FULL;
                            end
                            else
                            begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = ring_add(front_reg, occ_reg[IDX_W-1:0]);
                                occ_next    = occ_reg + 1'b1;
                            end
                        end
                        CMD_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                status_next = STS_EMPTY;
                            end
                            else
                            begin
                                front_next = ring_add(front_reg, IDX_W'(1));
                                occ_next   = occ_reg - 1'b1;
                            end
                        end
                        CMD_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                status_next = STS_EMPTY;
                            end
                            else
                            begin
                                occ_next = occ_reg - 1'b1;
                            end
                        end
                        CMD_FIND:
                        begin
                            if (is_empty)
                            begin
                                status_next = STS_NOT_FOUND;
                            end
                            else
                            begin
                                // result comes from the walk
                                out_valid_next = 1'b0;
                                key_next       = in_key;
                                rd_idx_next    = '0;
                                cmp_vld_next   = 1'b0;
                                state_next     = ST_SEARCH;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            if (is_empty)
                            begin
                                status_next = STS_EMPTY;
                            end
                            else
                            begin
                                occ_next   = '0;
                                front_next = '0;
                            end
                        end
                        default:
                        begin
                            status_next = STS_OK;
                        end
                    endcase
                    count_next = COUNT_W'(occ_next);
                end
            end
            ST_SEARCH:
            begin
                if (hit || last_cmp)
                begin
                    // hold the walk until the result register frees up
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = hit ? STS_OK : STS_NOT_FOUND;
                        pos_next       = hit ? POS_W'(cmp_idx_reg) : '0;
                        count_next     = COUNT_W'(occ_reg);
                        cmp_vld_next   = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    if (rd_idx_reg < occ_reg)
                    begin
                        ram_rd_en    = 1'b1;
                        cmp_idx_next = rd_idx_reg;
                        cmp_vld_next = 1'b1;
                        rd_idx_next  = rd_idx_reg + 1'b1;
                    end
                    else
                    begin
                        cmp_vld_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_reg     <= '0;
            occ_reg       <= '0;
            rd_idx_reg    <= '0;
            cmp_idx_reg   <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            occ_reg       <= occ_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_idx_reg   <= cmp_idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
        count_reg  <= count_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign position  = pos_reg;
    assign count     = count_reg;

    // occupancy never passes the ring size
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= DEPTH_C)
        else $error("occupancy above depth");

    // a walk only runs over a non-empty queue and never reads past its end
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (!is_empty && rd_idx_reg <= occ_reg))
        else $error("search walk out of bounds");

    // every command other than find has its result on the next edge
    a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && cmd != CMD_FIND) |=> out_valid)
        else $error("missing single-cycle result");

    // no new command is taken while a find is walking
    a_no_take_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> in_stall)
        else $error("command taken during search");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

// Checks the double-ended queue against a predictor built on an SV queue
// whose index 0 is the front entry.
// Every accepted command produces one predicted result, pushed into
// pending_results. Every result transfer is compared with the oldest
// prediction, one field at a time.
// Stimulus runs in these steps:
//   - directed commands on the empty and the full queue, with boundary values
//   - a random phase that leans toward pushes, so the queue fills up
//   - a drain step, where the sender waits until every result is back
//   - a balanced random phase
//   - a last phase in which neither side idles
module testbench;
    import dqs_pkg::*;

    // Codes 6 and 7 are not in cmd_t; the block must treat them as a no-op.
    localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

    localparam int CLK_HALF       = 6;
    localparam int STALL_LIMIT    = 1000;  // cycles with no transfer on either channel
    localparam int DRAIN_CYCLES   = 40;    // hold-off after the last result

    typedef struct packed {
        status_t              st;
        logic [POS_W-1:0]     pos;
        logic [COUNT_W-1:0]   cnt;
    } dq_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [CMD_W-1:0]           cmd;
    logic signed [VALUE_W-1:0]  value;
    logic                       out_valid;
    logic                       out_stall;
    logic [STATUS_W-1:0]        status;
    logic [POS_W-1:0]           position;
    logic [COUNT_W-1:0]         count;

    // Predictor state: index 0 is the front of the queue.
    logic [VALUE_W-1:0] model_entries[$];
    dq_result_t         pending_results[$];
    int                 error_count = 0;
    bit                 no_idle;        // set for the last phase: no gaps, no stalls
    int                 quiet_cycles = 0;

    double_ended_queue_with_search uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .position  (position),
        .count     (count)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Applies one command to the predictor and returns the result it should give.
    function automatic dq_result_t predict_result(logic [CMD_W-1:0] c_code,
                                                  logic [VALUE_W-1:0] v_data);
        dq_result_t r;
        bit         found;
        r.st  = STS_OK;
        r.pos = '0;
        found = 1'b0;
        case (c_code)
            CMD_PUSH_FRONT:
                if (model_entries.size() >= DEPTH_DEF) r.st = STS_FULL;
                else model_entries.push_front(v_data);
            CMD_PUSH_BACK:
                if (model_entries.size() >= DEPTH_DEF) r.st = STS_FULL;
                else model_entries.push_back(v_data);
            CMD_POP_FRONT:
                if (model_entries.size() == 0) r.st = STS_EMPTY;
                else void'(model_entries.pop_front());
            CMD_POP_BACK:
                if (model_entries.size() == 0) r.st = STS_EMPTY;
                else void'(model_entries.pop_back());
            CMD_FIND:
            begin
                r.st = STS_NOT_FOUND;
                foreach (model_entries[i])
                begin
                    if (!found && model_entries[i] == v_data)
                    begin
                        found = 1'b1;
                        r.st  = STS_OK;
                        r.pos = i[POS_W-1:0];
                    end
                end
            end
            CMD_CLEAR:
                if (model_entries.size() == 0) r.st = STS_EMPTY;
                else model_entries.delete();
            default: ;  // unused codes: no change, status OK
        endcase
        r.cnt = COUNT_W'(model_entries.size());
        return r;
    endfunction

    // Sends one command. It may first insert a gap. It returns at the clock edge
    // where the transfer happens, with in_valid still high, so the next call can
    // keep valid asserted without dropping it.
    task automatic send_cmd(logic [CMD_W-1:0] c_code, logic [VALUE_W-1:0] v_data);
        int gap;
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c_code;
        value    <= v_data;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(predict_result(c_code, v_data));
    endtask

    // Lowers valid and waits until every predicted result has been checked.
    task automatic wait_results_drained;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    // Picks a value: most come from a small pool, so duplicates and find hits
    // are frequent. The rest are fully random, so every bit toggles.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] pool[6];
        pool = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5};
        if ($urandom_range(0, 2) != 0) return pool[$urandom_range(0, 5)];
        return $urandom;
    endfunction

    // Picks a search key: usually an entry that is held at a random depth.
    function automatic logic [VALUE_W-1:0] pick_key();
        if (model_entries.size() != 0 && $urandom_range(0, 9) < 6)
            return model_entries[$urandom_range(0, model_entries.size() - 1)];
        return pick_value();
    endfunction

    // The push weight sets the drift. Above about 41% the queue tends to fill up.
    task automatic run_random_mix(int n_items, int push_w);
        int               r;
        logic [CMD_W-1:0] c_code;
        for (int k = 0; k < n_items; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < push_w)
                c_code = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
            else if (r < push_w + 15)
                c_code = CMD_FIND;
            else if (r < push_w + 17)
                c_code = CMD_CLEAR;
            else if (r < push_w + 19)
                c_code = $urandom_range(0, 1) ? CMD_RSVD_7 : CMD_RSVD_6;
            else
                c_code = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
            send_cmd(c_code, (c_code == CMD_FIND) ? pick_key() : pick_value());
        end
    endtask

    // Pop, clear, find and unused code 6 on an empty queue.
    task automatic test_empty_queue;
        send_cmd(CMD_POP_FRONT, 32'h0);
        send_cmd(CMD_POP_BACK, 32'h0);
        send_cmd(CMD_CLEAR, 32'h0);
        send_cmd(CMD_FIND, 32'h0);
        send_cmd(CMD_RSVD_6, 32'hFFFF_FFFF);
    endtask

    // Fills the queue from both ends with boundary values and pushes into a full
    // queue. Then it searches at the front and the back, and drains the queue.
    task automatic test_full_queue;
        for (int k = 0; k < DEPTH_DEF / 2; k++)
        begin
            send_cmd(CMD_PUSH_BACK, (k == 0) ? 32'h7FFF_FFFF : 32'h100 + k);
            send_cmd(CMD_PUSH_FRONT, (k == DEPTH_DEF / 2 - 1) ? 32'h8000_0000 : 32'h200 + k);
        end
        send_cmd(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
        send_cmd(CMD_PUSH_BACK, 32'h0);
        send_cmd(CMD_FIND, 32'h8000_0000);                  // front entry, position 0
        send_cmd(CMD_FIND, 32'h100 + DEPTH_DEF / 2 - 1);    // back entry, position 15
        send_cmd(CMD_FIND, 32'hDEAD_BEEF);                  // miss on a full queue
        send_cmd(CMD_POP_FRONT, 32'h0);
        send_cmd(CMD_POP_BACK, 32'h0);
        send_cmd(CMD_RSVD_7, 32'h0);
        send_cmd(CMD_CLEAR, 32'h0);
    endtask

    task automatic test_random_fill;
        run_random_mix(300, 60);
    endtask

    task automatic test_random_balanced;
        run_random_mix(300, 42);
    endtask

    // Transfers on both channels with no sender gaps and no receiver stall.
    task automatic test_full_rate;
        no_idle = 1'b1;
        run_random_mix(120, 50);
    endtask

    // Receiver stall: random bursts of random length, held low in the last phase.
    initial
    begin
        int stall_left;
        out_stall  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (no_idle)
            begin
                stall_left = 0;
                out_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic report_mismatch(string field, int exp_v, int act_v);
        $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, field, exp_v, act_v);
        error_count++;
    endtask

    // Result checker. It samples at the edge, so it sees the values from
    // before the edge.
    always @(posedge clk)
    begin
        dq_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: result transfer with nothing expected, status %0d count %0d",
                         $time, status, count);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (status !== exp_r.st) report_mismatch("status", exp_r.st, status);
                if (position !== exp_r.pos) report_mismatch("position", exp_r.pos, position);
                if (count !== exp_r.cnt) report_mismatch("count", exp_r.cnt, count);
            end
        end
    end

    // Watchdog: any transfer on either channel restarts the count.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        cmd          = CMD_PUSH_FRONT;
        value        = '0;
        no_idle      = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_full_queue();
        test_random_fill();
        wait_results_drained();
        test_random_balanced();
        test_full_rate();

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
